// File: design/zyx_euler_to_rotation_matrix_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Z-Y-X Euler to rotation matrix core
// Short forms for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ZYX_EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define ZYX_EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ZYX_ROT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold after the delay given by dly, counted from the antecedent
`define ZYX_ROT_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: design/zyx_rot_pkg.sv
// ----------------------------------------------------------------------------
// zyx_rot_pkg
// Types, constants and fixed-point helpers for the Z-Y-X Euler angle to
// rotation matrix core. Internal values are Q.30 in 32-bit signed words.
// ----------------------------------------------------------------------------
package zyx_rot_pkg;

    // Field formats
    localparam int ANGLE_W         = 16;
    localparam int OUT_W           = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS   = 14;

    // Internal Q.30 format; sums of two products need one bit more
    localparam int IFRAC = 30;
    localparam int Q_W   = 32;
    localparam int SUM_W = Q_W + 1;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_Z     = 0;
    localparam int AXIS_Y     = 1;
    localparam int AXIS_X     = 2;
    localparam int PIPE_DEPTH = 12;

    // Quadrant reduction
    localparam longint HALF_PI_Q     = 64'sd1686629713;
    localparam longint HALF_PI_HALF  = HALF_PI_Q / 2;
    localparam int     IN_SH         = IFRAC - ANGLE_FRAC_BITS;
    localparam int     U_W           = ANGLE_W + IN_SH;
    localparam longint ANGLE_MAG_MAX = 64'sd1 <<< (ANGLE_W - 1);
    localparam int     Q_MAX         = int'(((ANGLE_MAG_MAX <<< IN_SH) + HALF_PI_HALF)
                                           / HALF_PI_Q);
    localparam int     QUO_W         = ($clog2(Q_MAX + 1) > 2) ? $clog2(Q_MAX + 1) : 2;

    typedef logic signed [Q_W-1:0]   t_q30;
    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_q30 ONE_Q = t_q30'(64'd1 << IFRAC);

    // Series coefficients, Q.30
    localparam t_q30 SIN_K1 = 32'sd178956971;
    localparam t_q30 SIN_K2 = 32'sd8947849;
    localparam t_q30 SIN_K3 = 32'sd213044;
    localparam t_q30 SIN_K4 = 32'sd2959;
    localparam t_q30 COS_K1 = 32'sd536870912;
    localparam t_q30 COS_K2 = 32'sd44739243;
    localparam t_q30 COS_K3 = 32'sd1491308;
    localparam t_q30 COS_K4 = 32'sd26631;
    localparam t_q30 COS_K5 = 32'sd296;

    // Rounding and saturation constants
    localparam logic [2*Q_W-1:0] QMUL_RND = (2*Q_W)'(64'd1 << (IFRAC - 1));
    localparam int               OUT_SH   = IFRAC - OUT_FRAC_BITS;
    localparam logic [SUM_W:0]   OUT_RND  = (OUT_SH == 0) ? '0
                                          : (SUM_W + 1)'(64'd1 << (OUT_SH - 1));
    localparam longint OUT_FULL = 64'sd1 <<< OUT_FRAC_BITS;
    localparam longint OUT_MAXV = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam longint OUT_MINV = -(64'sd1 <<< (OUT_W - 1));
    localparam longint OUT_HI   = (OUT_FULL > OUT_MAXV) ? OUT_MAXV : OUT_FULL;
    localparam longint OUT_LO   = (-OUT_FULL < OUT_MINV) ? OUT_MINV : -OUT_FULL;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_z;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_x;
    } t_angles;

    typedef struct packed {
        logic signed [OUT_W-1:0] m_row0_col0;
        logic signed [OUT_W-1:0] m_row0_col1;
        logic signed [OUT_W-1:0] m_row0_col2;
        logic signed [OUT_W-1:0] m_row1_col0;
        logic signed [OUT_W-1:0] m_row1_col1;
        logic signed [OUT_W-1:0] m_row1_col2;
        logic signed [OUT_W-1:0] m_row2_col0;
        logic signed [OUT_W-1:0] m_row2_col1;
        logic signed [OUT_W-1:0] m_row2_col2;
    } t_matrix;

    // Q.30 product, rounded on the magnitude (halves away from zero)
    function automatic t_q30 qmul(t_q30 a, t_q30 b);
        logic             neg;
        logic [Q_W-1:0]   ua;
        logic [Q_W-1:0]   ub;
        logic [2*Q_W-1:0] p;
        logic [2*Q_W-1:0] pr;
        logic [Q_W-1:0]   m;
        neg = a[Q_W-1] ^ b[Q_W-1];
        ua  = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
        ub  = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
        p   = ua * ub;
        pr  = p + QMUL_RND;
        m   = pr[IFRAC +: Q_W];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Clamp to +-1.0
    function automatic t_q30 clamp_one(t_q30 v);
        t_q30 res;
        if (v > ONE_Q) begin
            res = ONE_Q;
        end else if (v < -ONE_Q) begin
            res = -ONE_Q;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Round Q.30 to the output format and saturate
    function automatic logic signed [OUT_W-1:0] to_out(t_sum v);
        logic [SUM_W-1:0]          mag;
        logic [SUM_W:0]            rnd;
        logic signed [SUM_W+1:0]   sv;
        logic signed [OUT_W-1:0]   res;
        mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
        rnd = ({1'b0, mag} + OUT_RND) >> OUT_SH;
        sv  = v[SUM_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        if (longint'(sv) > OUT_HI) begin
            res = OUT_W'(OUT_HI);
        end else if (longint'(sv) < OUT_LO) begin
            res = OUT_W'(OUT_LO);
        end else begin
            res = OUT_W'(sv);
        end
        return res;
    endfunction

    // True when an element lies inside the saturation limits
    function automatic logic out_in_range(logic signed [OUT_W-1:0] v);
        return (longint'(v) <= OUT_HI) && (longint'(v) >= OUT_LO);
    endfunction

endpackage

// File: design/zyx_euler_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// zyx_euler_to_rotation_matrix_core
// Z-Y-X Euler angles (Q3.13 radians) to the nine elements of Rz*Ry*Rx
// (Q1.14, rounded and saturated to +-1.0).
// ----------------------------------------------------------------------------
// Fully pipelined: one angle triple is taken every clock cycle and o_busy is
// always low. Each result appears on o_matrix with o_done high for one
// cycle, straight from the output register; results keep input order and the
// receiver cannot hold them off. The 12 stages are set by the multiplier
// chain: one stage of quadrant reduction, six stages of sine/cosine series
// (one 32x32 multiply per lane and stage), one of quadrant fix-up, two of
// matrix products, one adder stage and one rounding/saturation stage that
// drives the output register. The core keeps no state between items.

`include "zyx_euler_to_rotation_matrix_core_macros.svh"

module zyx_euler_to_rotation_matrix_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  zyx_rot_pkg::t_angles  i_angles,
    output logic                  o_busy,
    output logic                  o_done,
    output zyx_rot_pkg::t_matrix  o_matrix
);

    localparam int NA = zyx_rot_pkg::NUM_AXES;

    // Valid bits travel with the data
    logic [zyx_rot_pkg::PIPE_DEPTH-1:0] r_valid;
    logic                               w_accept;

    logic signed [zyx_rot_pkg::ANGLE_W-1:0] w_angle [NA];

    // Stage 1: reduced angle, quadrant and sign
    zyx_rot_pkg::t_q30                n_rem  [NA];
    logic [1:0]                       n_quad [NA];
    logic                             n_neg  [NA];

    zyx_rot_pkg::t_q30  r_rem  [1:6][NA];
    logic [1:0]         r_quad [1:7][NA];
    logic               r_neg  [1:7][NA];
    zyx_rot_pkg::t_q30  r_sq   [2:6][NA];
    zyx_rot_pkg::t_q30  r_ts   [3:6][NA];
    zyx_rot_pkg::t_q30  r_tc   [3:6][NA];
    zyx_rot_pkg::t_q30  r_sr   [NA];
    zyx_rot_pkg::t_q30  r_cr   [NA];
    zyx_rot_pkg::t_q30  n_sin  [NA];
    zyx_rot_pkg::t_q30  n_cos  [NA];
    zyx_rot_pkg::t_q30  r_sin  [NA];
    zyx_rot_pkg::t_q30  r_cos  [NA];

    // Stage 9: first products
    zyx_rot_pkg::t_q30  r_czsy, r_szsy, r_m00, r_m10, r_m21, r_m22;
    zyx_rot_pkg::t_q30  r_szcx9, r_szsx9, r_czcx9, r_czsx9, r_sx9, r_cx9, r_sy9;

    // Stage 10: triple products
    zyx_rot_pkg::t_q30  r_a01, r_a02, r_a11, r_a12;
    zyx_rot_pkg::t_q30  r_szcx10, r_szsx10, r_czcx10, r_czsx10;
    zyx_rot_pkg::t_q30  r_m00_10, r_m10_10, r_m21_10, r_m22_10, r_sy10;

    // Stage 11: unrounded elements
    zyx_rot_pkg::t_sum  r_elem [9];

    // Stage 12: output register
    zyx_rot_pkg::t_matrix r_matrix;

    logic w_out_ok;

    assign w_accept = i_start && !o_busy;

    assign w_angle[zyx_rot_pkg::AXIS_Z] = i_angles.angle_z;
    assign w_angle[zyx_rot_pkg::AXIS_Y] = i_angles.angle_y;
    assign w_angle[zyx_rot_pkg::AXIS_X] = i_angles.angle_x;

    // Advance the valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[zyx_rot_pkg::PIPE_DEPTH-2:0], w_accept};
        end
    end

    // Reduce each angle by the nearest multiple of pi/2
    always_comb begin
        logic [zyx_rot_pkg::ANGLE_W-1:0]   mag;
        logic [zyx_rot_pkg::U_W-1:0]       u;
        logic [zyx_rot_pkg::QUO_W-1:0]     quo;
        for (int i = 0; i < NA; i++) begin
            mag = w_angle[i][zyx_rot_pkg::ANGLE_W-1] ? zyx_rot_pkg::ANGLE_W'(-w_angle[i])
                                                     : zyx_rot_pkg::ANGLE_W'(w_angle[i]);
            u   = zyx_rot_pkg::U_W'(mag) << zyx_rot_pkg::IN_SH;
            quo = '0;
            for (int k = 1; k <= zyx_rot_pkg::Q_MAX; k++) begin
                if (64'(u) >= (64'(k) * 64'(zyx_rot_pkg::HALF_PI_Q)
                               - 64'(zyx_rot_pkg::HALF_PI_HALF))) begin
                    quo = zyx_rot_pkg::QUO_W'(k);
                end
            end
            n_rem[i]  = zyx_rot_pkg::t_q30'(64'(u)
                        - 64'(quo) * 64'(zyx_rot_pkg::HALF_PI_Q));
            n_quad[i] = quo[1:0];
            n_neg[i]  = w_angle[i][zyx_rot_pkg::ANGLE_W-1];
        end
    end

    // Put the quadrant and the sign back, clamp to +-1.0
    always_comb begin
        zyx_rot_pkg::t_q30 sv;
        zyx_rot_pkg::t_q30 cv;
        for (int i = 0; i < NA; i++) begin
            case (r_quad[7][i])
                2'd0: begin
                    sv = r_sr[i];
                    cv = r_cr[i];
                end
                2'd1: begin
                    sv = r_cr[i];
                    cv = -r_sr[i];
                end
                2'd2: begin
                    sv = -r_sr[i];
                    cv = -r_cr[i];
                end
                default: begin
                    sv = -r_cr[i];
                    cv = r_sr[i];
                end
            endcase
            if (r_neg[7][i]) begin
                sv = -sv;
            end
            n_sin[i] = zyx_rot_pkg::clamp_one(sv);
            n_cos[i] = zyx_rot_pkg::clamp_one(cv);
        end
    end

    // Sine and cosine series, one Horner step per stage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            // stage 1
            r_rem[1][i]  <= n_rem[i];
            r_quad[1][i] <= n_quad[i];
            r_neg[1][i]  <= n_neg[i];
            // carry remainder, quadrant and sign
            for (int st = 2; st <= 6; st++) begin
                r_rem[st][i] <= r_rem[st-1][i];
            end
            for (int st = 2; st <= 7; st++) begin
                r_quad[st][i] <= r_quad[st-1][i];
                r_neg[st][i]  <= r_neg[st-1][i];
            end
            for (int st = 3; st <= 6; st++) begin
                r_sq[st][i] <= r_sq[st-1][i];
            end
            // stage 2: square of the remainder
            r_sq[2][i] <= zyx_rot_pkg::qmul(r_rem[1][i], r_rem[1][i]);
            // stages 3 to 6: Horner steps
            r_ts[3][i] <= zyx_rot_pkg::SIN_K3 - zyx_rot_pkg::qmul(r_sq[2][i], zyx_rot_pkg::SIN_K4);
            r_tc[3][i] <= zyx_rot_pkg::COS_K4 - zyx_rot_pkg::qmul(r_sq[2][i], zyx_rot_pkg::COS_K5);
            r_ts[4][i] <= zyx_rot_pkg::SIN_K2 - zyx_rot_pkg::qmul(r_sq[3][i], r_ts[3][i]);
            r_tc[4][i] <= zyx_rot_pkg::COS_K3 - zyx_rot_pkg::qmul(r_sq[3][i], r_tc[3][i]);
            r_ts[5][i] <= zyx_rot_pkg::SIN_K1 - zyx_rot_pkg::qmul(r_sq[4][i], r_ts[4][i]);
            r_tc[5][i] <= zyx_rot_pkg::COS_K2 - zyx_rot_pkg::qmul(r_sq[4][i], r_tc[4][i]);
            r_ts[6][i] <= zyx_rot_pkg::ONE_Q  - zyx_rot_pkg::qmul(r_sq[5][i], r_ts[5][i]);
            r_tc[6][i] <= zyx_rot_pkg::COS_K1 - zyx_rot_pkg::qmul(r_sq[5][i], r_tc[5][i]);
            // stage 7: finish sine and cosine of the remainder
            r_sr[i] <= zyx_rot_pkg::qmul(r_rem[6][i], r_ts[6][i]);
            r_cr[i] <= zyx_rot_pkg::ONE_Q - zyx_rot_pkg::qmul(r_sq[6][i], r_tc[6][i]);
            // stage 8
            r_sin[i] <= n_sin[i];
            r_cos[i] <= n_cos[i];
        end
    end

    // Matrix products and sums
    always_ff @(posedge i_clk) begin
        // stage 9: pair products
        r_czsy  <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Z], r_sin[zyx_rot_pkg::AXIS_Y]);
        r_szsy  <= zyx_rot_pkg::qmul(r_sin[zyx_rot_pkg::AXIS_Z], r_sin[zyx_rot_pkg::AXIS_Y]);
        r_m00   <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Z], r_cos[zyx_rot_pkg::AXIS_Y]);
        r_m10   <= zyx_rot_pkg::qmul(r_sin[zyx_rot_pkg::AXIS_Z], r_cos[zyx_rot_pkg::AXIS_Y]);
        r_m21   <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Y], r_sin[zyx_rot_pkg::AXIS_X]);
        r_m22   <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Y], r_cos[zyx_rot_pkg::AXIS_X]);
        r_szcx9 <= zyx_rot_pkg::qmul(r_sin[zyx_rot_pkg::AXIS_Z], r_cos[zyx_rot_pkg::AXIS_X]);
        r_szsx9 <= zyx_rot_pkg::qmul(r_sin[zyx_rot_pkg::AXIS_Z], r_sin[zyx_rot_pkg::AXIS_X]);
        r_czcx9 <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Z], r_cos[zyx_rot_pkg::AXIS_X]);
        r_czsx9 <= zyx_rot_pkg::qmul(r_cos[zyx_rot_pkg::AXIS_Z], r_sin[zyx_rot_pkg::AXIS_X]);
        r_sx9   <= r_sin[zyx_rot_pkg::AXIS_X];
        r_cx9   <= r_cos[zyx_rot_pkg::AXIS_X];
        r_sy9   <= r_sin[zyx_rot_pkg::AXIS_Y];
        // stage 10: triple products, carry the rest
        r_a01    <= zyx_rot_pkg::qmul(r_czsy, r_sx9);
        r_a02    <= zyx_rot_pkg::qmul(r_czsy, r_cx9);
        r_a11    <= zyx_rot_pkg::qmul(r_szsy, r_sx9);
        r_a12    <= zyx_rot_pkg::qmul(r_szsy, r_cx9);
        r_szcx10 <= r_szcx9;
        r_szsx10 <= r_szsx9;
        r_czcx10 <= r_czcx9;
        r_czsx10 <= r_czsx9;
        r_m00_10 <= r_m00;
        r_m10_10 <= r_m10;
        r_m21_10 <= r_m21;
        r_m22_10 <= r_m22;
        r_sy10   <= r_sy9;
        // stage 11: sums
        r_elem[0] <= zyx_rot_pkg::t_sum'(r_m00_10);
        r_elem[1] <= zyx_rot_pkg::t_sum'(r_a01) - zyx_rot_pkg::t_sum'(r_szcx10);
        r_elem[2] <= zyx_rot_pkg::t_sum'(r_a02) + zyx_rot_pkg::t_sum'(r_szsx10);
        r_elem[3] <= zyx_rot_pkg::t_sum'(r_m10_10);
        r_elem[4] <= zyx_rot_pkg::t_sum'(r_a11) + zyx_rot_pkg::t_sum'(r_czcx10);
        r_elem[5] <= zyx_rot_pkg::t_sum'(r_a12) - zyx_rot_pkg::t_sum'(r_czsx10);
        r_elem[6] <= -zyx_rot_pkg::t_sum'(r_sy10);
        r_elem[7] <= zyx_rot_pkg::t_sum'(r_m21_10);
        r_elem[8] <= zyx_rot_pkg::t_sum'(r_m22_10);
        // stage 12: round and saturate into the output register
        r_matrix.m_row0_col0 <= zyx_rot_pkg::to_out(r_elem[0]);
        r_matrix.m_row0_col1 <= zyx_rot_pkg::to_out(r_elem[1]);
        r_matrix.m_row0_col2 <= zyx_rot_pkg::to_out(r_elem[2]);
        r_matrix.m_row1_col0 <= zyx_rot_pkg::to_out(r_elem[3]);
        r_matrix.m_row1_col1 <= zyx_rot_pkg::to_out(r_elem[4]);
        r_matrix.m_row1_col2 <= zyx_rot_pkg::to_out(r_elem[5]);
        r_matrix.m_row2_col0 <= zyx_rot_pkg::to_out(r_elem[6]);
        r_matrix.m_row2_col1 <= zyx_rot_pkg::to_out(r_elem[7]);
        r_matrix.m_row2_col2 <= zyx_rot_pkg::to_out(r_elem[8]);
    end

    assign o_busy   = 1'b0;
    assign o_done   = r_valid[zyx_rot_pkg::PIPE_DEPTH-1];
    assign o_matrix = r_matrix;

    // Saturation check over all nine elements
    assign w_out_ok = zyx_rot_pkg::out_in_range(r_matrix.m_row0_col0)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row0_col1)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row0_col2)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row1_col0)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row1_col1)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row1_col2)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row2_col0)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row2_col1)
                   && zyx_rot_pkg::out_in_range(r_matrix.m_row2_col2);

    // Every accepted item comes out of the pipeline with o_done set
    `ZYX_ROT_ASSERT_AFTER(a_item_latency, i_clk, i_rst_n, w_accept, (zyx_rot_pkg::PIPE_DEPTH), o_done, "item lost in pipeline")
    // No result without an item accepted at the pipeline input
    `ZYX_ROT_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_done, $past(w_accept, zyx_rot_pkg::PIPE_DEPTH), "result without item")
    // Delivered elements stay within the saturation limits
    `ZYX_ROT_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_done, w_out_ok, "element beyond saturation limit")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: Z-Y-X Euler angles to rotation matrix core
// Drives angle triples through the start/busy command port and checks every
// matrix strobed out on o_done, in order, against a fixed-point trig model
// kept in this bench. A short pose table (zero pose, +-pi, +-pi/2, quadrant
// edges, raw 16-bit extremes) runs first, then random poses with random
// sender gaps, a gap-free stretch and a drain in the middle.
// ----------------------------------------------------------------------------
module tb_top;

    // Q.30 trig model constants
    localparam int     FX_FRAC     = 30;
    localparam longint FX_ONE      = 64'sd1 <<< FX_FRAC;
    localparam longint RAD_HALF_PI = 64'sd1686629713;
    localparam int     ANG_SH      = FX_FRAC - zyx_rot_pkg::ANGLE_FRAC_BITS;
    localparam int     ELEM_SH     = FX_FRAC - zyx_rot_pkg::OUT_FRAC_BITS;
    localparam longint ELEM_LIM    = 64'sd1 <<< zyx_rot_pkg::OUT_FRAC_BITS;
    localparam int     ANG_PI      = 25736;
    localparam int     ANG_HALF_PI = 12868;

    // Run shape
    localparam int LATENCY    = zyx_rot_pkg::PIPE_DEPTH;
    localparam int NUM_RANDOM = 1700;
    localparam int CALM_FIRST = 600;
    localparam int CALM_LAST  = 899;
    localparam int DRAIN_AT   = 1200;
    localparam int WDOG_LIMIT = 2000;

    localparam zyx_rot_pkg::t_matrix UNIT_MATRIX = '{16'sd16384, 16'sd0, 16'sd0,
                                                     16'sd0, 16'sd16384, 16'sd0,
                                                     16'sd0, 16'sd0, 16'sd16384};

    typedef struct {
        zyx_rot_pkg::t_angles ang;
        bit                   has_want;
        zyx_rot_pkg::t_matrix want;
    } t_pose_row;

    // Directed poses; only the zero pose has its matrix typed in
    t_pose_row pose_tbl[24] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, UNIT_MATRIX},
        '{'{16'sd25736, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{-16'sd25736, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd25736, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd25736, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd25736}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd25736}, 1'b0, '0},
        '{'{16'sd12868, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd12868, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, -16'sd12868, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, -16'sd12868}, 1'b0, '0},
        '{'{16'sd6434, 16'sd6434, 16'sd6434}, 1'b0, '0},
        '{'{-16'sd6434, -16'sd6434, -16'sd6434}, 1'b0, '0},
        '{'{16'sd6433, -16'sd6435, 16'sd6435}, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
        '{'{16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
        '{'{-16'sd1, 16'sd1, -16'sd1}, 1'b0, '0},
        '{'{16'sd21845, -16'sd21846, 16'sd21845}, 1'b0, '0},
        '{'{-16'sd21846, 16'sd21845, -16'sd21846}, 1'b0, '0},
        '{'{16'sd25736, 16'sd25736, 16'sd25736}, 1'b0, '0},
        '{'{-16'sd25736, 16'sd25736, -16'sd25736}, 1'b0, '0},
        '{'{16'sd19302, 16'sd12868, -16'sd19302}, 1'b0, '0},
        '{'{16'sd8192, -16'sd8192, 16'sd16384}, 1'b0, '0}
    };

    string elem_name[9] = '{"m_row0_col0", "m_row0_col1", "m_row0_col2",
                            "m_row1_col0", "m_row1_col1", "m_row1_col2",
                            "m_row2_col0", "m_row2_col1", "m_row2_col2"};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    zyx_rot_pkg::t_angles i_angles;
    logic                 o_busy;
    logic                 o_done;
    zyx_rot_pkg::t_matrix o_matrix;

    zyx_rot_pkg::t_matrix matrix_q[$];
    zyx_rot_pkg::t_matrix drv_want;
    int                   err_cnt;
    int                   checked_cnt;
    int                   accepted_cnt;
    int                   stall_cnt;

    zyx_euler_to_rotation_matrix_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_angles (i_angles),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_matrix (o_matrix)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Q.30 product, magnitude rounded half away from zero
    function automatic longint fx_mul(longint a, longint b);
        bit              ng;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        ng = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p  = (ua * ub + (64'd1 << (FX_FRAC - 1))) >> FX_FRAC;
        return ng ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint sat_unit(longint v);
        if (v > FX_ONE) begin
            return FX_ONE;
        end
        if (v < -FX_ONE) begin
            return -FX_ONE;
        end
        return v;
    endfunction

    // Sine and cosine of a raw angle: fold to nearest quadrant, run the series,
    // then restore quadrant and sign
    function automatic void trig_pair(input logic [15:0] raw, output longint s,
                                      output longint c);
        longint x;
        longint u;
        longint q;
        longint r;
        longint r2;
        longint t;
        longint sr;
        longint cr;
        longint sv;
        longint cv;
        bit     ng;
        x  = longint'($signed(raw)) * (64'sd1 <<< ANG_SH);
        ng = x < 0;
        u  = ng ? -x : x;
        q  = (u + RAD_HALF_PI / 2) / RAD_HALF_PI;
        r  = u - q * RAD_HALF_PI;
        r2 = fx_mul(r, r);

        t  = 64'sd213044 - fx_mul(r2, 64'sd2959);
        t  = 64'sd8947849 - fx_mul(r2, t);
        t  = 64'sd178956971 - fx_mul(r2, t);
        t  = FX_ONE - fx_mul(r2, t);
        sr = fx_mul(r, t);

        t  = 64'sd26631 - fx_mul(r2, 64'sd296);
        t  = 64'sd1491308 - fx_mul(r2, t);
        t  = 64'sd44739243 - fx_mul(r2, t);
        t  = 64'sd536870912 - fx_mul(r2, t);
        cr = FX_ONE - fx_mul(r2, t);

        case (q[1:0])
            2'd0: begin
                sv = sr;
                cv = cr;
            end
            2'd1: begin
                sv = cr;
                cv = -sr;
            end
            2'd2: begin
                sv = -sr;
                cv = -cr;
            end
            default: begin
                sv = -cr;
                cv = sr;
            end
        endcase
        if (ng) begin
            sv = -sv;
        end
        s = sat_unit(sv);
        c = sat_unit(cv);
    endfunction

    // Q.30 to output element: round half away from zero, saturate to +-1.0
    function automatic logic signed [15:0] to_elem(longint v);
        longint unsigned m;
        longint          r;
        m = (v < 0) ? -v : v;
        if (ELEM_SH > 0) begin
            m = (m + (64'd1 << (ELEM_SH - 1))) >> ELEM_SH;
        end
        r = (v < 0) ? -longint'(m) : longint'(m);
        if (r > ELEM_LIM) r = ELEM_LIM;
        if (r < -ELEM_LIM) r = -ELEM_LIM;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic zyx_rot_pkg::t_matrix predict_matrix(zyx_rot_pkg::t_angles a);
        longint               sz;
        longint               cz;
        longint               sy;
        longint               cy;
        longint               sx;
        longint               cx;
        longint               czsy;
        longint               szsy;
        zyx_rot_pkg::t_matrix m;
        trig_pair(a.angle_z, sz, cz);
        trig_pair(a.angle_y, sy, cy);
        trig_pair(a.angle_x, sx, cx);
        czsy = fx_mul(cz, sy);
        szsy = fx_mul(sz, sy);
        m.m_row0_col0 = to_elem(fx_mul(cz, cy));
        m.m_row0_col1 = to_elem(fx_mul(czsy, sx) - fx_mul(sz, cx));
        m.m_row0_col2 = to_elem(fx_mul(czsy, cx) + fx_mul(sz, sx));
        m.m_row1_col0 = to_elem(fx_mul(sz, cy));
        m.m_row1_col1 = to_elem(fx_mul(szsy, sx) + fx_mul(cz, cx));
        m.m_row1_col2 = to_elem(fx_mul(szsy, cx) - fx_mul(cz, sx));
        m.m_row2_col0 = to_elem(-sy);
        m.m_row2_col1 = to_elem(fx_mul(cy, sx));
        m.m_row2_col2 = to_elem(fx_mul(cy, cx));
        return m;
    endfunction

    // Mostly in-range angles, some raw 16-bit patterns, some near quadrant edges
    function automatic logic signed [15:0] rand_angle();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            return 16'(int'($urandom_range(0, 2 * ANG_PI)) - ANG_PI);
        end
        if (pick < 88) begin
            return 16'($urandom);
        end
        k = int'($urandom_range(0, 4)) - 2;
        return 16'(k * ANG_HALF_PI + int'($urandom_range(0, 8)) - 4);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // Check each strobed matrix against the oldest expectation, then log any
    // item taken at this edge
    always @(posedge i_clk) begin
        zyx_rot_pkg::t_matrix want;
        bit                   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                moved = 1'b1;
                if (matrix_q.size() == 0) begin
                    report_mismatch("matrix strobed with none outstanding");
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (o_matrix[(8 - k) * 16 +: 16] !== want[(8 - k) * 16 +: 16]) begin
                            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                checked_cnt, elem_name[k],
                                $signed(o_matrix[(8 - k) * 16 +: 16]),
                                $signed(want[(8 - k) * 16 +: 16])));
                        end
                    end
                    checked_cnt++;
                end
            end
            if (i_start && o_busy === 1'b0) begin
                moved = 1'b1;
                matrix_q.push_back(drv_want);
                accepted_cnt++;
            end
            // Stop a hung run
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= WDOG_LIMIT) begin
                $display("Watchdog: no progress for %0d cycles", WDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Present one item at a falling edge, idling first at random, and hold it
    // until a rising edge takes it
    task automatic send_triple(input zyx_rot_pkg::t_angles ang,
                               input zyx_rot_pkg::t_matrix want, input bit calm);
        bit taken;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 26) begin
            i_start  <= 1'b0;
            i_angles <= {16'($urandom), 16'($urandom), 16'($urandom)};
            @(negedge i_clk);
        end
        i_start  <= 1'b1;
        i_angles <= ang;
        drv_want <= want;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = i_start && o_busy === 1'b0;
        end
    endtask

    // Hold off the sender until every outstanding matrix has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (matrix_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        zyx_rot_pkg::t_angles ang;
        int                   wide_cnt;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_angles     = '0;
        drv_want     = '0;
        err_cnt      = 0;
        checked_cnt  = 0;
        accepted_cnt = 0;
        stall_cnt    = 0;
        wide_cnt     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed poses
        foreach (pose_tbl[i]) begin
            send_triple(pose_tbl[i].ang,
                        pose_tbl[i].has_want ? pose_tbl[i].want
                                             : predict_matrix(pose_tbl[i].ang),
                        1'b0);
        end
        drain_results();

        // Random poses: one gap-free stretch, one drain part way through
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == DRAIN_AT) begin
                drain_results();
            end
            ang.angle_z = rand_angle();
            ang.angle_y = rand_angle();
            ang.angle_x = rand_angle();
            wide_cnt += int'($signed(ang.angle_z) > ANG_PI || $signed(ang.angle_z) < -ANG_PI)
                      + int'($signed(ang.angle_y) > ANG_PI || $signed(ang.angle_y) < -ANG_PI)
                      + int'($signed(ang.angle_x) > ANG_PI || $signed(ang.angle_x) < -ANG_PI);
            send_triple(ang, predict_matrix(ang), n >= CALM_FIRST && n <= CALM_LAST);
        end
        drain_results();
        repeat (LATENCY + 4) @(negedge i_clk);

        $display("Sent %0d directed and %0d random angle triples; %0d random angles lay past +-pi.",
                 $size(pose_tbl), NUM_RANDOM, wide_cnt);
        $display("Took %0d items and compared %0d matrices field by field; %0d mismatches.",
                 accepted_cnt, checked_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
